>>> hw/rtl/ipcfs_pkg.sv
// package for the two-core mailbox: operation codes, state types, queue sizing
// used by interprocessor_fifo_and_sync_top; depends on nothing
`timescale 1ns / 1ps

package ipcfs_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		OP_CTRL_RD  = 3'd0,
		OP_CTRL_WR  = 3'd1,
		OP_SEND     = 3'd2,
		OP_RECV     = 3'd3,
		OP_IRQ_UPD  = 3'd4,
		OP_SYNC_RD  = 3'd5,
		OP_SYNC_WR  = 3'd6
	} op_t;

	typedef struct packed {
		logic enable;
		logic error;
		logic recv_irq;
		logic send_irq;
	} ctrl_t;

	typedef struct packed {
		logic       enable;
		logic [3:0] out_bits;
	} sync_t;

	typedef struct packed {
		logic recv_cond;
		logic send_cond;
	} prev_t;

	// control register bit positions
	localparam int CT_SEND_EMPTY = 0;
	localparam int CT_SEND_FULL  = 1;
	localparam int CT_SEND_IRQ   = 2;
	localparam int CT_CLEAR      = 3;
	localparam int CT_RECV_EMPTY = 8;
	localparam int CT_RECV_FULL  = 9;
	localparam int CT_RECV_IRQ   = 10;
	localparam int CT_ERROR      = 14;
	localparam int CT_ENABLE     = 15;

	// sync register bit positions
	localparam int SY_IN_LO  = 0;
	localparam int SY_OUT_LO = 8;
	localparam int SY_REQ    = 13;
	localparam int SY_ENABLE = 14;

endpackage

>>> hw/rtl/interprocessor_fifo_and_sync_top.sv
// two-core mailbox: two word queues, control and sync registers, irq pulses
// depends on ipcfs_pkg
`timescale 1ns / 1ps

// Usage
// Slave channel: one register access per beat. s_tdata carries the write word,
// s_tuser carries op, core and byte_sel. Master channel: one result per beat,
// m_tdata carries the read word, m_tuser the interrupt target and raise flags.
// Every access gives exactly one result beat, in order.
// An accepted beat passes through the input register, then the result register,
// to the master side. Throughput: one beat per cycle while the receiver does
// not stall, set by the single read-modify-write of the queue and register
// state that sits between the input register and the result register.
// Reset (arst_n low) empties both queues, clears control, sync and irq edge
// state and drops both valid flags; queue words are not cleared, since a word
// is only read after it has been written.
// When the receiver stalls, the result register holds and the input register
// fills; s_tready then falls until the result is taken.
module interprocessor_fifo_and_sync_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // write_data
	input  logic [4:0]  s_tuser,  // op[2:0], core[3], byte_sel[4]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // read_data
	output logic [3:0]  m_tuser   // irq_core, raise_send_empty, raise_recv_not_empty, raise_sync
);
	import ipcfs_pkg::*;

	// input stage
	logic        valid_s1;
	op_t         op_s1;
	logic        core_s1;
	logic [31:0] wdata_s1;
	logic        bsel_s1;

	// result stage
	logic        valid_s2;
	logic [31:0] rdata_s2;
	logic        icore_s2;
	logic        r_send_s2;
	logic        r_recv_s2;
	logic        r_sync_s2;

	// state
	logic [31:0]      ring_q [2][QUEUE_DEPTH];
	logic [PTR_W-1:0] head_q [2];
	logic [CNT_W-1:0] cnt_q  [2];
	ctrl_t            ctrl_q [2];
	prev_t            prev_q [2];
	sync_t            sync_q [2];

	logic [PTR_W-1:0] head_nxt [2];
	logic [CNT_W-1:0] cnt_nxt  [2];
	ctrl_t            ctrl_nxt [2];
	prev_t            prev_nxt [2];
	sync_t            sync_nxt [2];

	logic             advance;
	logic             rq;
	logic [15:0]      ctrl_val;
	logic [15:0]      sync_val;
	logic [PTR_W:0]   tail_sum;
	logic [PTR_W-1:0] tail;
	logic [PTR_W-1:0] rhead;
	logic             ring_we;
	logic             send_full;
	logic             recv_empty;
	logic             se_cond;
	logic             rn_cond;
	logic [31:0]      rdata_c;
	logic             icore_c;
	logic             r_send_c;
	logic             r_recv_c;
	logic             r_sync_c;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	assign m_tvalid = valid_s2;
	assign m_tdata  = rdata_s2;
	assign m_tuser  = {r_sync_s2, r_recv_s2, r_send_s2, icore_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (!valid_s2 || m_tready)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1    <= op_t'(s_tuser[2:0]);
			core_s1  <= s_tuser[3];
			bsel_s1  <= s_tuser[4];
			wdata_s1 <= s_tdata;
		end
		if (advance) begin
			rdata_s2  <= rdata_c;
			icore_s2  <= icore_c;
			r_send_s2 <= r_send_c;
			r_recv_s2 <= r_recv_c;
			r_sync_s2 <= r_sync_c;
		end
		if (advance && ring_we)
			ring_q[core_s1][tail] <= wdata_s1;
	end

	// live views of the accessing core's registers
	assign rq        = ~core_s1;
	assign send_full = (cnt_q[core_s1] == CNT_W'(QUEUE_DEPTH));
	assign recv_empty = (cnt_q[rq] == '0);
	assign rhead     = head_q[rq];

	always_comb begin
		ctrl_val                = '0;
		ctrl_val[CT_SEND_EMPTY] = (cnt_q[core_s1] == '0);
		ctrl_val[CT_SEND_FULL]  = send_full;
		ctrl_val[CT_SEND_IRQ]   = ctrl_q[core_s1].send_irq;
		ctrl_val[CT_RECV_EMPTY] = recv_empty;
		ctrl_val[CT_RECV_FULL]  = (cnt_q[rq] == CNT_W'(QUEUE_DEPTH));
		ctrl_val[CT_RECV_IRQ]   = ctrl_q[core_s1].recv_irq;
		ctrl_val[CT_ERROR]      = ctrl_q[core_s1].error;
		ctrl_val[CT_ENABLE]     = ctrl_q[core_s1].enable;
	end

	always_comb begin
		sync_val                        = '0;
		sync_val[SY_IN_LO +: 4]         = sync_q[rq].out_bits;
		sync_val[SY_OUT_LO +: 4]        = sync_q[core_s1].out_bits;
		sync_val[SY_ENABLE]             = sync_q[core_s1].enable;
	end

	// write slot: head plus count, wrapped once
	always_comb begin
		tail_sum = (PTR_W+1)'(head_q[core_s1]) + (PTR_W+1)'(cnt_q[core_s1]);
		if (tail_sum >= (PTR_W+1)'(QUEUE_DEPTH))
			tail_sum = tail_sum - (PTR_W+1)'(QUEUE_DEPTH);
		tail = tail_sum[PTR_W-1:0];
	end

	assign se_cond = ctrl_val[CT_SEND_IRQ] && ctrl_val[CT_SEND_EMPTY];
	assign rn_cond = ctrl_val[CT_RECV_IRQ] && !ctrl_val[CT_RECV_EMPTY];

	always_comb begin
		head_nxt = head_q;
		cnt_nxt  = cnt_q;
		ctrl_nxt = ctrl_q;
		prev_nxt = prev_q;
		sync_nxt = sync_q;
		ring_we  = 1'b0;
		rdata_c  = '0;
		icore_c  = core_s1;
		r_send_c = 1'b0;
		r_recv_c = 1'b0;
		r_sync_c = 1'b0;
		case (op_s1)
			OP_CTRL_RD: begin
				rdata_c = 32'(ctrl_val);
			end
			OP_CTRL_WR: begin
				if (wdata_s1[CT_CLEAR]) begin
					head_nxt[core_s1] = '0;
					cnt_nxt[core_s1]  = '0;
				end
				if (wdata_s1[CT_ERROR]) begin
					ctrl_nxt[core_s1].error = 1'b0;
				end else begin
					ctrl_nxt[core_s1].send_irq = wdata_s1[CT_SEND_IRQ];
					ctrl_nxt[core_s1].recv_irq = wdata_s1[CT_RECV_IRQ];
					ctrl_nxt[core_s1].enable   = wdata_s1[CT_ENABLE];
				end
			end
			OP_SEND: begin
				if (ctrl_q[core_s1].enable) begin
					if (send_full) begin
						ctrl_nxt[core_s1].error = 1'b1;
					end else begin
						ring_we          = 1'b1;
						cnt_nxt[core_s1] = cnt_q[core_s1] + 1'b1;
					end
				end
			end
			OP_RECV: begin
				if (recv_empty) begin
					ctrl_nxt[core_s1].error = 1'b1;
				end else begin
					rdata_c      = ring_q[rq][rhead];
					head_nxt[rq] = (rhead == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rhead + 1'b1;
					cnt_nxt[rq]  = cnt_q[rq] - 1'b1;
				end
			end
			OP_IRQ_UPD: begin
				r_send_c                   = se_cond && !prev_q[core_s1].send_cond;
				r_recv_c                   = rn_cond && !prev_q[core_s1].recv_cond;
				prev_nxt[core_s1].send_cond = se_cond;
				prev_nxt[core_s1].recv_cond = rn_cond;
			end
			OP_SYNC_RD: begin
				rdata_c = bsel_s1 ? 32'(sync_val[15:8]) : 32'(sync_val[7:0]);
			end
			OP_SYNC_WR: begin
				icore_c = rq;
				// only the high byte holds stored bits
				if (bsel_s1) begin
					sync_nxt[core_s1].out_bits = wdata_s1[SY_OUT_LO-8 +: 4];
					sync_nxt[core_s1].enable   = wdata_s1[SY_ENABLE-8];
					r_sync_c = wdata_s1[SY_REQ-8] && sync_q[rq].enable;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				head_q[i] <= '0;
				cnt_q[i]  <= '0;
				ctrl_q[i] <= '0;
				prev_q[i] <= '0;
				sync_q[i] <= '0;
			end
		end else if (advance) begin
			head_q <= head_nxt;
			cnt_q  <= cnt_nxt;
			ctrl_q <= ctrl_nxt;
			prev_q <= prev_nxt;
			sync_q <= sync_nxt;
		end
	end

endmodule

>>> hw/rtl/ipcfs_chk.sv
// port-level checks for the two-core mailbox, bound to its top level
// depends on interprocessor_fifo_and_sync_top
`timescale 1ns / 1ps

module ipcfs_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [3:0]  m_tuser
);

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// an empty result stage never blocks the input side
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result stage");

	// irq raises come only from an update or a sync write, neither returns data
	a_irq_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1] || m_tuser[2] || m_tuser[3]) |-> m_tdata == 32'd0)
		else $error("irq raise with nonzero read data");

	// sync raise and queue raises never share a beat
	a_irq_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[3] |-> !m_tuser[1] && !m_tuser[2])
		else $error("sync raise together with queue raise");

endmodule

bind interprocessor_fifo_and_sync_top ipcfs_chk u_ipcfs_chk (.*);
